// ===== src/bpc_pkg.sv =====
// package: shared constants, codes and types of the button press classifier
package bpc_pkg;

    // fixed field widths
    localparam int SLOT_W     = 3;
    localparam int NOW_W      = 32;
    localparam int THR_W      = 32;
    localparam int ACT_W      = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE      = 2'd2;

    // register reset values
    localparam logic [THR_W-1:0] LONG_PRESS_RST  = 32'd1000;
    localparam logic [THR_W-1:0] SHORT_PRESS_RST = 32'd50;
    localparam logic [ACT_W-1:0] ACTIVE_RST      = 4'd8;

    // event kinds
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    // parameter defaults
    localparam int BUTTON_SLOTS_DEF = 8;
    localparam int TIME_BITS_DEF    = 32;

    // configuration register set
    typedef struct packed {
        logic [THR_W-1:0] long_press_ticks;
        logic [THR_W-1:0] short_press_ticks;
        logic [ACT_W-1:0] active_slots;
    } cfg_t;

    // classification outcome of one item
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              kind;
    } event_t;

endpackage

// ===== src/bpc_if.sv =====
// interfaces: sample channel and event channel

interface bpc_sample_if;
    logic                       valid;
    logic                       ready;
    logic [bpc_pkg::SLOT_W-1:0] slot;
    logic                       pin_level;
    logic [bpc_pkg::NOW_W-1:0]  now_time;

    modport source (output valid, slot, pin_level, now_time, input ready);
    modport sink   (input valid, slot, pin_level, now_time, output ready);
endinterface

interface bpc_event_if;
    logic                       valid;
    logic                       ready;
    logic [bpc_pkg::SLOT_W-1:0] event_slot;
    logic                       event_kind;

    modport source (output valid, event_slot, event_kind, input ready);
    modport sink   (input valid, event_slot, event_kind, output ready);
endinterface

// ===== src/bpc_cfg_regs.sv =====
// configuration registers with plain write port
module bpc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]     wr_data,
    output bpc_pkg::cfg_t                      cfg
);

    bpc_pkg::cfg_t cfg_reg;
    bpc_pkg::cfg_t cfg_next;

    // decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                bpc_pkg::REG_LONG_PRESS:
                    cfg_next.long_press_ticks = wr_data[bpc_pkg::THR_W-1:0];
                bpc_pkg::REG_SHORT_PRESS:
                    cfg_next.short_press_ticks = wr_data[bpc_pkg::THR_W-1:0];
                bpc_pkg::REG_ACTIVE:
                    cfg_next.active_slots = wr_data[bpc_pkg::ACT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks  <= bpc_pkg::LONG_PRESS_RST;
            cfg_reg.short_press_ticks <= bpc_pkg::SHORT_PRESS_RST;
            cfg_reg.active_slots      <= bpc_pkg::ACTIVE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/bpc_classifier.sv =====
// per-slot state and press classification for the registered item
module bpc_classifier #(
    parameter int BUTTON_SLOTS = bpc_pkg::BUTTON_SLOTS_DEF,
    parameter int TIME_BITS    = bpc_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid,
    input  logic                           advance,
    input  logic [bpc_pkg::SLOT_W-1:0]     slot,
    input  logic                           pin_level,
    input  logic [bpc_pkg::NOW_W-1:0]      now_time,
    input  bpc_pkg::cfg_t                  cfg,
    output bpc_pkg::event_t                res
);

    localparam int IDX_W = (BUTTON_SLOTS > 1) ? $clog2(BUTTON_SLOTS) : 1;
    localparam int CMP_W = (TIME_BITS > bpc_pkg::THR_W) ? TIME_BITS : bpc_pkg::THR_W;

    logic [BUTTON_SLOTS-1:0] was_pressed_reg;
    logic [BUTTON_SLOTS-1:0] reported_reg;
    logic [TIME_BITS-1:0]    press_start_reg [BUTTON_SLOTS];

    logic                 active;
    logic [IDX_W-1:0]     idx;
    logic                 cur;
    logic                 prev;
    logic                 rep;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] held;
    logic                 long_met;
    logic                 short_met;

    logic                 reported_next;
    logic [TIME_BITS-1:0] press_start_next;

    // slot lookup
    always_comb
    begin
        active = (32'(slot) < BUTTON_SLOTS) &&
                 ({1'b0, slot} < cfg.active_slots);
        idx    = IDX_W'(slot);
        cur    = ~pin_level;
        prev   = active ? was_pressed_reg[idx] : 1'b0;
        rep    = active ? reported_reg[idx] : 1'b0;
        now_t  = TIME_BITS'(now_time);
        held   = now_t - (active ? press_start_reg[idx] : '0);
        long_met  = CMP_W'(held) >= CMP_W'(cfg.long_press_ticks);
        short_met = CMP_W'(held) >= CMP_W'(cfg.short_press_ticks);
    end

    // classification and next state for the addressed slot
    always_comb
    begin
        reported_next    = rep;
        press_start_next = active ? press_start_reg[idx] : '0;
        res.hit          = 1'b0;
        res.slot         = slot;
        res.kind         = bpc_pkg::KIND_SHORT;
        if (cur && !prev && !rep)
        begin
            press_start_next = now_t;
        end
        else if (cur && prev && !rep)
        begin
            if (long_met)
            begin
                reported_next    = 1'b1;
                press_start_next = '0;
                res.hit          = valid && active;
                res.kind         = bpc_pkg::KIND_LONG;
            end
        end
        else if (!cur && prev && !rep)
        begin
            if (short_met)
            begin
                reported_next = 1'b1;
                res.hit       = valid && active;
                res.kind      = bpc_pkg::KIND_SHORT;
            end
            press_start_next = '0;
        end
        else if (!cur && rep)
        begin
            reported_next    = 1'b0;
            press_start_next = '0;
        end
    end

    // state write-back when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg <= '0;
            reported_reg    <= '0;
            for (int k = 0; k < BUTTON_SLOTS; k++)
            begin
                press_start_reg[k] <= '0;
            end
        end
        else if (advance && active)
        begin
            was_pressed_reg[idx] <= cur;
            reported_reg[idx]    <= reported_next;
            press_start_reg[idx] <= press_start_next;
        end
    end

endmodule

// ===== src/bpc_out_stage.sv =====
// output register for classified events
module bpc_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bpc_pkg::event_t    res,
    output logic               busy,
    bpc_event_if.source        events
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [bpc_pkg::SLOT_W-1:0] slot_reg;
    logic                       kind_reg;

    // hold until taken, reload on a new event
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (events.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= res.slot;
            kind_reg <= res.kind;
        end
    end

    assign busy              = valid_reg && !events.ready;
    assign events.valid      = valid_reg;
    assign events.event_slot = slot_reg;
    assign events.event_kind = kind_reg;

endmodule

// ===== src/button_press_classifier_top.sv =====
// top level of the button press classifier
//
//  channel   dir  handshake            payload
//  samples   in   valid / ready        slot, pin_level, now_time
//  events    out  valid / ready        event_slot, event_kind
//  wr_*      in   wr_en, no wait       wr_index, wr_data
//
// one item per cycle unless the output is blocked; an accepted item passes the input register,
// then its event is loaded into the event register and held there until taken
// the per-slot read-modify-write sits between the input and event registers
// reset clears all slot state and loads the register defaults
// samples stalls only while an event waits in the output and the next item
// also yields an event
module button_press_classifier_top #(
    parameter int BUTTON_SLOTS = bpc_pkg::BUTTON_SLOTS_DEF,
    parameter int TIME_BITS    = bpc_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bpc_sample_if.sink                     samples,
    bpc_event_if.source                    events,
    input  logic                           wr_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] wr_data
);

    bpc_pkg::cfg_t   cfg;
    bpc_pkg::event_t res;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [bpc_pkg::SLOT_W-1:0] s1_slot_reg;
    logic                       s1_pin_reg;
    logic [bpc_pkg::NOW_W-1:0]  s1_now_reg;

    logic out_busy;
    logic advance;
    logic accept;

    bpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // item leaves the input register unless its event has nowhere to go
    assign advance       = s1_valid_reg && !(out_busy && res.hit);
    assign samples.ready = !s1_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;

    // input register
    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg <= samples.slot;
            s1_pin_reg  <= samples.pin_level;
            s1_now_reg  <= samples.now_time;
        end
    end

    bpc_classifier #(
        .BUTTON_SLOTS (BUTTON_SLOTS),
        .TIME_BITS    (TIME_BITS)
    ) u_classifier (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (s1_valid_reg),
        .advance   (advance),
        .slot      (s1_slot_reg),
        .pin_level (s1_pin_reg),
        .now_time  (s1_now_reg),
        .cfg       (cfg),
        .res       (res)
    );

    bpc_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && res.hit),
        .res    (res),
        .busy   (out_busy),
        .events (events)
    );

endmodule

// ===== src/bpc_checker.sv =====
// port-level checker for the button press classifier, with its bind
module bpc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [bpc_pkg::SLOT_W-1:0] out_slot,
    input logic                       out_kind
);

    // a waiting event holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_kind))
        else $error("event changed while stalled");

    // input stalls only behind a blocked event
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a blocked event");

    // a fresh event comes from an accepted item
    a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("event without a matching item");

    // no event right after reset
    a_reset_clean: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !out_valid)
        else $error("event present after reset");

endmodule

bind button_press_classifier_top bpc_checker u_bpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (events.valid),
    .out_ready (events.ready),
    .out_slot  (events.event_slot),
    .out_kind  (events.event_kind)
);

// ===== tb/sv/button_press_classifier_top_test.sv =====
`timescale 1ns / 100ps
// testbench: directed and random press sequences checked against a slot-state predictor
module button_press_classifier_top_test;

    localparam int SLOTS        = bpc_pkg::BUTTON_SLOTS_DEF;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 230;

    logic                           clk;
    logic                           rst_n;
    logic                           wr_en;
    logic [bpc_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [bpc_pkg::CFG_DATA_W-1:0] wr_data;

    bpc_sample_if sample_ch();
    bpc_event_if  event_ch();

    button_press_classifier_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_ch),
        .events   (event_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // shadow registers and per-slot state of the predictor
    logic [bpc_pkg::THR_W-1:0] long_thr;
    logic [bpc_pkg::THR_W-1:0] short_thr;
    logic [bpc_pkg::ACT_W-1:0] slots_in_use;
    logic                      held_down  [SLOTS];
    logic                      flagged    [SLOTS];
    logic [bpc_pkg::NOW_W-1:0] down_since [SLOTS];

    // classified presses still to come out of the block
    bpc_pkg::event_t pending_events[$];

    int errors       = 0;
    int quiet_cycles = 0;
    bit bursts_on    = 1'b1;

    // stimulus generator: pin level per slot and a running clock
    logic                      gen_level [SLOTS];
    logic [bpc_pkg::NOW_W-1:0] gen_now;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // predictor: classify one sample and update the slot state
    function automatic bpc_pkg::event_t classify_sample(
        input logic [bpc_pkg::SLOT_W-1:0] slot,
        input logic                       pin,
        input logic [bpc_pkg::NOW_W-1:0]  now);
        bpc_pkg::event_t           ev;
        logic                      down;
        logic [bpc_pkg::NOW_W-1:0] held;
        ev      = '0;
        ev.slot = slot;
        if (slot >= slots_in_use)
            return ev;
        down = ~pin;
        held = now - down_since[slot];
        if (down && !held_down[slot] && !flagged[slot])
        begin
            down_since[slot] = now;
        end
        else if (down && held_down[slot] && !flagged[slot])
        begin
            if (held >= long_thr)
            begin
                flagged[slot]    = 1'b1;
                down_since[slot] = '0;
                ev.hit           = 1'b1;
                ev.kind          = bpc_pkg::KIND_LONG;
            end
        end
        else if (!down && held_down[slot] && !flagged[slot])
        begin
            if (held >= short_thr)
            begin
                flagged[slot] = 1'b1;
                ev.hit        = 1'b1;
                ev.kind       = bpc_pkg::KIND_SHORT;
            end
            down_since[slot] = '0;
        end
        else if (!down && flagged[slot])
        begin
            flagged[slot]    = 1'b0;
            down_since[slot] = '0;
        end
        held_down[slot] = down;
        return ev;
    endfunction

    task automatic reset_predictor();
        long_thr     = bpc_pkg::LONG_PRESS_RST;
        short_thr    = bpc_pkg::SHORT_PRESS_RST;
        slots_in_use = bpc_pkg::ACTIVE_RST;
        for (int k = 0; k < SLOTS; k++)
        begin
            held_down[k]  = 1'b0;
            flagged[k]    = 1'b0;
            down_since[k] = '0;
            gen_level[k]  = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // send one sample item and predict its outcome once accepted
    task automatic send_sample(input logic [bpc_pkg::SLOT_W-1:0] slot, input logic pin,
                               input logic [bpc_pkg::NOW_W-1:0] now);
        bpc_pkg::event_t ev;
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.slot      <= slot;
        sample_ch.pin_level <= pin;
        sample_ch.now_time  <= now;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        ev = classify_sample(slot, pin, now);
        if (ev.hit)
            pending_events.push_back(ev);
    endtask

    // stop sending and wait until the block has nothing left in flight
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpc_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            bpc_pkg::REG_LONG_PRESS:  long_thr     = data;
            bpc_pkg::REG_SHORT_PRESS: short_thr    = data;
            bpc_pkg::REG_ACTIVE:      slots_in_use = data[bpc_pkg::ACT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [bpc_pkg::THR_W-1:0] long_ticks,
                                input logic [bpc_pkg::THR_W-1:0] short_ticks,
                                input logic [bpc_pkg::ACT_W-1:0] active);
        settle();
        write_reg(bpc_pkg::REG_LONG_PRESS, long_ticks);
        write_reg(bpc_pkg::REG_SHORT_PRESS, short_ticks);
        write_reg(bpc_pkg::REG_ACTIVE, bpc_pkg::CFG_DATA_W'(active));
    endtask

    // reset thresholds: long hold, too-short release, short release,
    // release while flagged, wrap of the time difference, idle release
    task automatic test_default_thresholds();
        send_sample(3'd0, 1'b0, 32'd10);
        send_sample(3'd0, 1'b0, 32'd1010);
        send_sample(3'd0, 1'b1, 32'd1600);
        send_sample(3'd1, 1'b0, 32'd2000);
        send_sample(3'd1, 1'b1, 32'd2049);
        send_sample(3'd1, 1'b0, 32'd3000);
        send_sample(3'd1, 1'b1, 32'd3050);
        send_sample(3'd2, 1'b0, 32'd4200);
        send_sample(3'd2, 1'b0, 32'd9000);
        send_sample(3'd2, 1'b1, 32'd9100);
        send_sample(3'd7, 1'b0, 32'hFFFF_FFFF);
        send_sample(3'd7, 1'b0, 32'd999);
        send_sample(3'd6, 1'b1, 32'd0);
    endtask

    // thresholds of zero are met at once
    task automatic test_zero_thresholds();
        apply_config('0, '0, 4'd8);
        send_sample(3'd3, 1'b0, 32'hFFFF_FFFF);
        send_sample(3'd3, 1'b0, 32'hFFFF_FFFF);
        send_sample(3'd3, 1'b1, 32'd5);
        send_sample(3'd4, 1'b0, 32'd77);
        send_sample(3'd4, 1'b1, 32'd77);
    endtask

    // largest thresholds need a full wrap of the time difference
    task automatic test_max_thresholds();
        apply_config('1, '1, 4'd8);
        send_sample(3'd5, 1'b0, 32'd100);
        send_sample(3'd5, 1'b0, 32'd99);
        send_sample(3'd5, 1'b1, 32'd100);
        send_sample(3'd5, 1'b0, 32'd200);
        send_sample(3'd5, 1'b1, 32'd199);
    endtask

    // slots at or above the active count are ignored
    task automatic test_active_slots();
        apply_config(bpc_pkg::LONG_PRESS_RST, bpc_pkg::SHORT_PRESS_RST, 4'd0);
        send_sample(3'd0, 1'b0, 32'd0);
        send_sample(3'd7, 1'b0, 32'd5000);
        apply_config(bpc_pkg::LONG_PRESS_RST, bpc_pkg::SHORT_PRESS_RST, 4'd1);
        send_sample(3'd1, 1'b0, 32'd6000);
        send_sample(3'd0, 1'b0, 32'd7000);
        send_sample(3'd0, 1'b0, 32'd8000);
    endtask

    // one random sample: mostly a coherent press pattern, some noise
    task automatic random_sample(input int step_max);
        logic [bpc_pkg::SLOT_W-1:0] slot;
        logic                       pin;
        logic [bpc_pkg::NOW_W-1:0]  now;
        int                         roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
        begin
            slot = bpc_pkg::SLOT_W'($urandom);
            pin  = 1'($urandom);
            now  = bpc_pkg::NOW_W'($urandom);
        end
        else
        begin
            if (slots_in_use != 0 && roll >= 15)
                slot = bpc_pkg::SLOT_W'($urandom_range(0, slots_in_use - 1));
            else
                slot = bpc_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 99) < 35)
                gen_level[slot] = ~gen_level[slot];
            gen_now = gen_now + bpc_pkg::NOW_W'($urandom_range(0, step_max));
            pin     = gen_level[slot];
            now     = gen_now;
        end
        send_sample(slot, pin, now);
    endtask

    // random press traffic over several threshold settings
    task automatic test_random_presses();
        int long_tab  [PHASES] = '{1000, 20, 0, 300, 150, 600};
        int short_tab [PHASES] = '{50, 5, 0, 100, 200, 40};
        int act_tab   [PHASES] = '{8, 8, 5, 3, 8, 8};
        int step_tab  [PHASES] = '{400, 30, 10, 150, 250, 300};
        for (int p = 0; p < PHASES; p++)
        begin
            apply_config(bpc_pkg::THR_W'(long_tab[p]), bpc_pkg::THR_W'(short_tab[p]),
                         bpc_pkg::ACT_W'(act_tab[p]));
            bursts_on = (p < PHASES - 1);
            gen_now   = bpc_pkg::NOW_W'($urandom);
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_sample(step_tab[p]);
        end
    endtask

    // event sink readiness with random stall bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                event_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            event_ch.ready <= 1'b1;
        end
    end

    // compare each event item with the oldest prediction
    always @(posedge clk)
    begin
        bpc_pkg::event_t want;
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected event slot %0d kind %0d",
                                          event_ch.event_slot, event_ch.event_kind));
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_ch.event_slot !== want.slot)
                    report_mismatch($sformatf("event_slot %0d, predicted %0d",
                                              event_ch.event_slot, want.slot));
                if (event_ch.event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d on slot %0d, predicted %0d",
                                              event_ch.event_kind, want.slot, want.kind));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("button_press_classifier_top_test failed");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n               <= 1'b0;
        wr_en               <= 1'b0;
        wr_index            <= bpc_pkg::REG_LONG_PRESS;
        wr_data             <= '0;
        sample_ch.valid     <= 1'b0;
        sample_ch.slot      <= '0;
        sample_ch.pin_level <= 1'b1;
        sample_ch.now_time  <= '0;
        event_ch.ready      <= 1'b0;
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_default_thresholds();
        test_zero_thresholds();
        test_max_thresholds();
        test_active_slots();
        test_random_presses();
        settle();

        if (errors == 0)
            $display("button_press_classifier_top_test passed");
        else
            $display("button_press_classifier_top_test failed");
        $finish;
    end

endmodule
